/* hdl/forest_fire_ca_update_defines.svh */
// Assertion helpers used by the checker file.
`ifndef FOREST_FIRE_CA_UPDATE_DEFINES_SVH
`define FOREST_FIRE_CA_UPDATE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define FFCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FFCA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ffca_pkg.sv */
package ffca_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = 7;
  localparam int COORD_W    = $clog2(MAX_SIDE);
  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = 12;
  localparam int COUNT_W    = $clog2(CELL_COUNT + 1);
  localparam int DRAW_W     = 16;
  localparam int THR_W      = DRAW_W + 1;

  localparam logic [1:0] CELL_ROCK    = 2'd0;
  localparam logic [1:0] CELL_TREE    = 2'd1;
  localparam logic [1:0] CELL_BURNING = 2'd2;
  localparam logic [1:0] CELL_BURNT   = 2'd3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [1:0]        cell_value;
    logic [DRAW_W-1:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        cell_state;
    logic [ADDR_W-1:0] cell_index;
    logic              last_of_pass;
  } out_item_t;

  // Ignition threshold floor((2s + 54) * 65536 / 70) in unsigned 1.16 fixed point.
  function automatic logic [THR_W-1:0] ignite_threshold(input logic [3:0] burning);
    logic [THR_W-1:0] thr;
    case (burning)
      4'd1:    thr = 17'd52428;
      4'd2:    thr = 17'd54301;
      4'd3:    thr = 17'd56173;
      4'd4:    thr = 17'd58046;
      4'd5:    thr = 17'd59918;
      4'd6:    thr = 17'd61791;
      4'd7:    thr = 17'd63663;
      4'd8:    thr = 17'd65536;
      default: thr = 17'd0;
    endcase
    return thr;
  endfunction

endpackage

/* hdl/forest_fire_ca_update.sv */
// Forest-fire cellular automaton on a square toroidal grid of up to 64 x 64 cells, one cell
// per item in raster order. Both grids sit in single-port memories. An update item reads the
// nine cells it needs (the cell and its eight neighbors) one per cycle from the current-grid
// memory. The block is ready for the next item in the same cycle a result appears. The first
// item after a write to grid_side turns the raster position back into row and column, one
// quotient bit per cycle, unless the position lies beyond the new grid, when it restarts at 0.
// An update of the last cell of the grid is followed by a copy of the whole next-grid memory,
// all 4096 cells, into the current grid, one cell per cycle, during which no item is accepted.
// A result waits in an output register, so the next item can be accepted before it is taken.
module forest_fire_ca_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ffca_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ffca_pkg::out_item_t                 out_data,
  input  logic                                cfg_write_en,
  input  logic [ffca_pkg::SIDE_W-1:0]         cfg_write_data
);
  import ffca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DISPATCH,
    S_READ,
    S_FINISH,
    S_COPY
  } state_t;

  localparam logic [3:0] NB_LAST = 4'd8;
  localparam logic [3:0] NB_DONE = 4'd9;
  localparam logic [3:0] DIV_TOP = 4'(ADDR_W - 1);

  state_t               state;
  logic [SIDE_W-1:0]    grid_side;
  logic                 coords_stale;
  logic [ADDR_W-1:0]    pos;
  logic [COORD_W-1:0]   x, y;
  logic                 op;
  logic [1:0]           value;
  logic [DRAW_W-1:0]    draw;
  logic [3:0]           rd_k;
  logic [1:0]           center;
  logic [3:0]           burn_cnt;
  logic [3:0]           div_cnt;
  logic [COORD_W-1:0]   div_rem;
  logic [ADDR_W-1:0]    div_quot;
  logic [COUNT_W-1:0]   copy_cnt;

  logic [1:0] cur_mem [CELL_COUNT];
  logic [1:0] nxt_mem [CELL_COUNT];
  logic [1:0] cur_rd, nxt_rd;

  logic [SIDE_W-1:0]    side_eff;
  logic [COUNT_W-1:0]   total;
  logic                 pos_last, pos_beyond;
  logic [COORD_W-1:0]   side_m1, xm1, xp1, ym1, yp1;
  logic [COORD_W-1:0]   nb_x, nb_y;
  logic [ADDR_W-1:0]    nb_addr;
  logic [SIDE_W-1:0]    div_trial;
  logic                 div_ge;
  logic [COORD_W-1:0]   div_rem_new;
  logic [ADDR_W-1:0]    div_quot_new;
  logic [1:0]           new_state;
  logic                 x_wrap;
  logic                 finish_go;
  logic [ADDR_W-1:0]    cur_addr, nxt_addr;
  logic                 cur_we, cur_re, nxt_we, nxt_re;
  logic [1:0]           cur_wdata;

  // Register values outside 3..64 act as the nearest legal side.
  always_comb begin
    if (grid_side < SIDE_W'(3)) begin
      side_eff = SIDE_W'(3);
    end else if (grid_side > SIDE_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = grid_side;
    end
  end

  assign total      = COUNT_W'(side_eff) * COUNT_W'(side_eff);
  assign pos_last   = ({1'b0, pos} == total - COUNT_W'(1));
  assign pos_beyond = ({1'b0, pos} >= total);
  assign side_m1    = COORD_W'(side_eff - SIDE_W'(1));

  assign xm1    = (x == '0) ? side_m1 : x - COORD_W'(1);
  assign x_wrap = ({1'b0, x} + SIDE_W'(1) >= side_eff);
  assign xp1    = x_wrap ? '0 : x + COORD_W'(1);
  assign ym1    = (y == '0) ? side_m1 : y - COORD_W'(1);
  assign yp1    = ({1'b0, y} + SIDE_W'(1) >= side_eff) ? '0 : y + COORD_W'(1);

  // Read order: the cell itself first, then its eight neighbors row by row.
  always_comb begin
    case (rd_k)
      4'd1:    begin nb_y = ym1; nb_x = xm1; end
      4'd2:    begin nb_y = ym1; nb_x = x;   end
      4'd3:    begin nb_y = ym1; nb_x = xp1; end
      4'd4:    begin nb_y = y;   nb_x = xm1; end
      4'd5:    begin nb_y = y;   nb_x = xp1; end
      4'd6:    begin nb_y = yp1; nb_x = xm1; end
      4'd7:    begin nb_y = yp1; nb_x = x;   end
      4'd8:    begin nb_y = yp1; nb_x = xp1; end
      default: begin nb_y = y;   nb_x = x;   end
    endcase
  end

  assign nb_addr = ADDR_W'(COUNT_W'(nb_y) * COUNT_W'(side_eff) + COUNT_W'(nb_x));

  // Restoring division of the raster position by the side, one bit per cycle.
  assign div_trial    = {div_rem, pos[div_cnt]};
  assign div_ge       = (div_trial >= side_eff);
  assign div_rem_new  = div_ge ? COORD_W'(div_trial - side_eff) : COORD_W'(div_trial);
  assign div_quot_new = {div_quot[ADDR_W-2:0], div_ge};

  always_comb begin
    if (op == OP_LOAD) begin
      new_state = value;
    end else begin
      case (center)
        CELL_ROCK: new_state = CELL_ROCK;
        CELL_TREE: begin
          if (burn_cnt == '0) begin
            new_state = CELL_TREE;
          end else if ({1'b0, draw} < ignite_threshold(burn_cnt)) begin
            new_state = CELL_BURNING;
          end else begin
            new_state = CELL_TREE;
          end
        end
        default:   new_state = CELL_BURNT;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign finish_go = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    case (state)
      S_READ:  cur_addr = nb_addr;
      S_COPY:  cur_addr = ADDR_W'(copy_cnt - COUNT_W'(1));
      default: cur_addr = pos;
    endcase
  end

  assign cur_we    = (finish_go && op == OP_LOAD) || (state == S_COPY && copy_cnt != '0);
  assign cur_wdata = (state == S_COPY) ? nxt_rd : value;
  assign cur_re    = (state == S_READ) && (rd_k <= NB_LAST);

  assign nxt_addr = (state == S_COPY) ? copy_cnt[ADDR_W-1:0] : pos;
  assign nxt_we   = finish_go;
  assign nxt_re   = (state == S_COPY) && (copy_cnt < COUNT_W'(CELL_COUNT));

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_addr] <= cur_wdata;
    end
    if (cur_re) begin
      cur_rd <= cur_mem[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_addr] <= new_state;
    end
    if (nxt_re) begin
      nxt_rd <= nxt_mem[nxt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      grid_side    <= SIDE_W'(MAX_SIDE);
      coords_stale <= 1'b0;
      pos          <= '0;
      x            <= '0;
      y            <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        grid_side    <= cfg_write_data;
        coords_stale <= 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_data.opcode;
            value <= in_data.cell_value;
            draw  <= in_data.random_draw;
            if (pos_beyond) begin
              pos          <= '0;
              x            <= '0;
              y            <= '0;
              coords_stale <= 1'b0;
              state        <= S_DISPATCH;
            end else if (coords_stale) begin
              div_cnt  <= DIV_TOP;
              div_rem  <= '0;
              div_quot <= '0;
              state    <= S_DIV;
            end else begin
              state <= S_DISPATCH;
            end
          end
        end
        S_DIV: begin
          div_rem  <= div_rem_new;
          div_quot <= div_quot_new;
          if (div_cnt == '0) begin
            x            <= div_rem_new;
            y            <= div_quot_new[COORD_W-1:0];
            coords_stale <= 1'b0;
            state        <= S_DISPATCH;
          end else begin
            div_cnt <= div_cnt - 4'd1;
          end
        end
        S_DISPATCH: begin
          if (op == OP_LOAD) begin
            state <= S_FINISH;
          end else begin
            rd_k     <= '0;
            burn_cnt <= '0;
            state    <= S_READ;
          end
        end
        S_READ: begin
          // Read data comes back in the cycle after its read was issued.
          if (rd_k == 4'd1) begin
            center <= cur_rd;
          end else if (rd_k != '0 && cur_rd == CELL_BURNING) begin
            burn_cnt <= burn_cnt + 4'd1;
          end
          rd_k <= rd_k + 4'd1;
          if (rd_k == NB_DONE) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish_go) begin
            out_valid             <= 1'b1;
            out_data.cell_state   <= new_state;
            out_data.cell_index   <= pos;
            out_data.last_of_pass <= pos_last;
            if (pos_last) begin
              pos <= '0;
              x   <= '0;
              y   <= '0;
              if (op == OP_UPDATE) begin
                copy_cnt <= '0;
                state    <= S_COPY;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              pos <= pos + ADDR_W'(1);
              if (x_wrap) begin
                x <= '0;
                y <= y + COORD_W'(1);
              end else begin
                x <= x + COORD_W'(1);
              end
              state <= S_IDLE;
            end
          end
        end
        S_COPY: begin
          copy_cnt <= copy_cnt + COUNT_W'(1);
          if (copy_cnt == COUNT_W'(CELL_COUNT)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/ffca_check.sv */
`include "forest_fire_ca_update_defines.svh"

module ffca_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ffca_pkg::out_item_t out_data
);
  import ffca_pkg::*;

  `FFCA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `FFCA_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while one is at work")
  `FFCA_ASSERT(a_last_index, out_valid && out_data.last_of_pass |-> out_data.cell_index >= ADDR_W'(8), "last cell of a grid below the smallest side")
  `FFCA_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result present right after reset")

endmodule

bind forest_fire_ca_update ffca_check u_ffca_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
